// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the decimal parser.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every rising clock edge, skipped while reset is active.
`define CHK_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is active.
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adn_pkg.sv =====
// Package for the ASCII decimal parser: types, character codes, widths.
// No dependencies.
package adn_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_START  = 3'd1,
    PH_INT    = 3'd2,
    PH_FRAC   = 3'd3,
    PH_ESTART = 3'd4,
    PH_EDIG   = 3'd5,
    PH_DONE   = 3'd6
  } ph_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_PREP = 3'd1,
    ST_UP   = 3'd2,
    ST_DIV  = 3'd3,
    ST_EMIT = 3'd4
  } state_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int CHAR_W  = 8;
  localparam int VAL_W   = 48;
  localparam int MANT_W  = 60;
  localparam int DCNT_W  = 5;
  localparam int DSH_W   = 8;
  localparam int EXPV_W  = 7;
  localparam int EXP_W   = 10;

  localparam logic [VAL_W-1:0] MAX_Q = 48'h7FFF_FFFF_FFFF;

  localparam int DEF_MANTISSA_DIGITS = 18;
  localparam int DEF_FRAC_BITS       = 16;
  localparam int DEF_EXP_LIMIT       = 99;

endpackage

// ===== rtl/adn_in_if.sv =====
// Input channel interface of the decimal parser: one character per transfer.
// Depends on adn_pkg.
interface adn_in_if;
  logic                        valid;
  logic                        ready;
  logic [adn_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/adn_out_if.sv =====
// Result channel interface of the decimal parser: one value per transfer.
// Depends on adn_pkg.
interface adn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adn_pkg::VAL_W-1:0]  value;
  logic                              saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink   (input valid, input value, input saturated, output ready);
endinterface

// ===== rtl/ascii_decimal_to_number_core.sv =====
// Top level of the ASCII decimal parser; uses adn_pkg, adn_in_if, adn_out_if
// and assert_macros.svh.
//
// Takes one character per transfer. The last character starts the scaling
// sequencer: a set-up state, then either one multiply by ten per unit of
// positive exponent, or for a negative exponent one pass of a shared
// divide-by-ten unit per unit (4 quotient bits a cycle), stopping early once
// the value reaches zero; then the result register is loaded. A large positive
// exponent saturates the value; the longest run is a negative exponent of 23
// or more, where the value reaches zero after at most 23 passes. The input is
// not ready while the sequencer runs or a result is waiting to load.
`include "assert_macros.svh"

module ascii_decimal_to_number_core #(
  parameter int MANTISSA_DIGITS = adn_pkg::DEF_MANTISSA_DIGITS,
  parameter int FRAC_BITS       = adn_pkg::DEF_FRAC_BITS,
  parameter int EXP_LIMIT       = adn_pkg::DEF_EXP_LIMIT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [adn_pkg::CHAR_W-1:0] cfg_wr_data,
  adn_in_if.sink                     in_ch,
  adn_out_if.source                  out_ch
);

  localparam int WORK_W = ((adn_pkg::MANT_W + FRAC_BITS + 3) / 4) * 4;
  localparam int STEPS  = WORK_W / 4;
  localparam int SC_W   = $clog2(STEPS + 1);
  localparam logic [WORK_W-1:0] LIM    = WORK_W'(adn_pkg::MAX_Q >> FRAC_BITS);
  localparam logic [WORK_W-1:0] LIM_10 = WORK_W'((adn_pkg::MAX_Q >> FRAC_BITS) / 10);
  localparam logic [WORK_W-1:0] MAXQ_W = WORK_W'(adn_pkg::MAX_Q);
  localparam logic [adn_pkg::DCNT_W-1:0] MDIG = adn_pkg::DCNT_W'(MANTISSA_DIGITS);
  localparam logic [10:0] ELIM = 11'(EXP_LIMIT);

  // Registers
  adn_pkg::state_t                 state_r, state_nxt;
  adn_pkg::ph_t                    phase_r, phase_nxt;
  logic [adn_pkg::CHAR_W-1:0]      prefix_r;
  logic [adn_pkg::CHAR_W-1:0]      skip_r, skip_nxt;
  logic                            neg_r, neg_nxt;
  logic [adn_pkg::MANT_W-1:0]      mant_r, mant_nxt;
  logic [adn_pkg::DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic signed [adn_pkg::DSH_W-1:0] dsh_r, dsh_nxt;
  logic                            eneg_r, eneg_nxt;
  logic [adn_pkg::EXPV_W-1:0]      expv_r, expv_nxt;
  logic [WORK_W-1:0]               work_r, work_nxt;
  logic signed [adn_pkg::EXP_W-1:0] e_r, e_nxt;
  logic [SC_W-1:0]                 sc_r, sc_nxt;
  logic [3:0]                      rem_r, rem_nxt;
  logic                            rneg_r, rneg_nxt;
  logic [adn_pkg::VAL_W-1:0]       rmag_r, rmag_nxt;
  logic                            rsat_r, rsat_nxt;
  logic                            ovld_r, ovld_nxt;
  logic signed [adn_pkg::VAL_W-1:0] oval_r, oval_nxt;
  logic                            osat_r, osat_nxt;

  // Combinational helpers
  logic                            acc;
  logic                            dig;
  logic [3:0]                      dval;
  adn_pkg::ph_t                    ph;
  logic [10:0]                     etmp;
  logic signed [adn_pkg::EXP_W-1:0] esum;
  logic [3:0]                      dq;
  logic [3:0]                      dr;
  logic [4:0]                      dt;
  logic [WORK_W-1:0]               upsh;
  logic                            load;

  assign acc  = in_ch.valid && in_ch.ready;
  assign dig  = in_ch.char_code inside {[adn_pkg::CH_ZERO:adn_pkg::CH_NINE]};
  assign dval = 4'(in_ch.char_code - adn_pkg::CH_ZERO);
  assign esum = $signed({{(adn_pkg::EXP_W-adn_pkg::DSH_W){dsh_r[adn_pkg::DSH_W-1]}}, dsh_r})
              + (eneg_r ? -$signed({3'b000, expv_r}) : $signed({3'b000, expv_r}));
  assign upsh = work_r << FRAC_BITS;
  assign load = (state_r == adn_pkg::ST_EMIT) && (!ovld_r || out_ch.ready);

  // Shared divide-by-ten step: four quotient bits per cycle
  always_comb begin
    dr = rem_r;
    dq = '0;
    dt = '0;
    for (int k = 0; k < 4; k++) begin
      dt = {dr, work_r[WORK_W-1-k]};
      if (dt >= 5'd10) begin
        dq[3-k] = 1'b1;
        dt = dt - 5'd10;
      end
      dr = dt[3:0];
    end
  end

  // Character parser and scaling sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    neg_nxt   = neg_r;
    mant_nxt  = mant_r;
    dcnt_nxt  = dcnt_r;
    dsh_nxt   = dsh_r;
    eneg_nxt  = eneg_r;
    expv_nxt  = expv_r;
    work_nxt  = work_r;
    e_nxt     = e_r;
    sc_nxt    = sc_r;
    rem_nxt   = rem_r;
    rneg_nxt  = rneg_r;
    rmag_nxt  = rmag_r;
    rsat_nxt  = rsat_r;
    ph        = phase_r;
    etmp      = '0;
    case (state_r)
      adn_pkg::ST_IDLE: begin
        if (acc) begin
          if (phase_r == adn_pkg::PH_SKIP && skip_r < prefix_r) begin
            skip_nxt = skip_r + 8'd1;
          end else begin
            ph = (phase_r == adn_pkg::PH_SKIP) ? adn_pkg::PH_START : phase_r;
            phase_nxt = ph;
            etmp = 11'(expv_r) * 11'd10 + 11'(dval);
            case (ph)
              adn_pkg::PH_START, adn_pkg::PH_INT: begin
                if (ph == adn_pkg::PH_START && in_ch.char_code == adn_pkg::CH_MINUS) begin
                  neg_nxt = 1'b1;
                  phase_nxt = adn_pkg::PH_INT;
                end else if (ph == adn_pkg::PH_START &&
                             in_ch.char_code == adn_pkg::CH_PLUS) begin
                  phase_nxt = adn_pkg::PH_INT;
                end else if (dig) begin
                  phase_nxt = adn_pkg::PH_INT;
                  if (!(mant_r == '0 && dval == 4'd0)) begin
                    if (dcnt_r < MDIG) begin
                      mant_nxt = (mant_r << 3) + (mant_r << 1) + adn_pkg::MANT_W'(dval);
                      dcnt_nxt = dcnt_r + 5'd1;
                    end else if (dsh_r != 8'sd127) begin
                      dsh_nxt = dsh_r + 8'sd1;
                    end
                  end
                end else if (in_ch.char_code == adn_pkg::CH_DOT) begin
                  phase_nxt = adn_pkg::PH_FRAC;
                end else if (in_ch.char_code == adn_pkg::CH_E_LO ||
                             in_ch.char_code == adn_pkg::CH_E_UP) begin
                  phase_nxt = adn_pkg::PH_ESTART;
                end else begin
                  phase_nxt = adn_pkg::PH_DONE;
                end
              end
              adn_pkg::PH_FRAC: begin
                if (dig) begin
                  if (mant_r == '0 && dval == 4'd0) begin
                    if (dsh_r != -8'sd128) dsh_nxt = dsh_r - 8'sd1;
                  end else if (dcnt_r < MDIG) begin
                    mant_nxt = (mant_r << 3) + (mant_r << 1) + adn_pkg::MANT_W'(dval);
                    dcnt_nxt = dcnt_r + 5'd1;
                    if (dsh_r != -8'sd128) dsh_nxt = dsh_r - 8'sd1;
                  end
                end else if (in_ch.char_code == adn_pkg::CH_E_LO ||
                             in_ch.char_code == adn_pkg::CH_E_UP) begin
                  phase_nxt = adn_pkg::PH_ESTART;
                end else begin
                  phase_nxt = adn_pkg::PH_DONE;
                end
              end
              adn_pkg::PH_ESTART, adn_pkg::PH_EDIG: begin
                if (ph == adn_pkg::PH_ESTART && in_ch.char_code == adn_pkg::CH_MINUS) begin
                  eneg_nxt = 1'b1;
                  phase_nxt = adn_pkg::PH_EDIG;
                end else if (ph == adn_pkg::PH_ESTART &&
                             in_ch.char_code == adn_pkg::CH_PLUS) begin
                  phase_nxt = adn_pkg::PH_EDIG;
                end else if (dig) begin
                  phase_nxt = adn_pkg::PH_EDIG;
                  expv_nxt = (etmp > ELIM) ? adn_pkg::EXPV_W'(ELIM)
                                           : adn_pkg::EXPV_W'(etmp);
                end else begin
                  phase_nxt = adn_pkg::PH_DONE;
                end
              end
              default: phase_nxt = adn_pkg::PH_DONE;
            endcase
          end
          if (in_ch.last_char) state_nxt = adn_pkg::ST_PREP;
        end
      end
      adn_pkg::ST_PREP: begin
        // latch sign and exponent, clear the parse state for the next string
        rneg_nxt = neg_r;
        rsat_nxt = 1'b0;
        rmag_nxt = '0;
        e_nxt    = esum;
        rem_nxt  = '0;
        sc_nxt   = '0;
        if (mant_r == '0) begin
          state_nxt = adn_pkg::ST_EMIT;
        end else if (!esum[adn_pkg::EXP_W-1]) begin
          work_nxt = WORK_W'(mant_r);
          if (WORK_W'(mant_r) > LIM) begin
            rsat_nxt  = 1'b1;
            rmag_nxt  = adn_pkg::MAX_Q;
            state_nxt = adn_pkg::ST_EMIT;
          end else begin
            state_nxt = adn_pkg::ST_UP;
          end
        end else begin
          work_nxt  = WORK_W'(mant_r) << FRAC_BITS;
          state_nxt = adn_pkg::ST_DIV;
        end
        phase_nxt = adn_pkg::PH_SKIP;
        skip_nxt  = '0;
        neg_nxt   = 1'b0;
        mant_nxt  = '0;
        dcnt_nxt  = '0;
        dsh_nxt   = '0;
        eneg_nxt  = 1'b0;
        expv_nxt  = '0;
      end
      adn_pkg::ST_UP: begin
        // one multiply by ten per cycle
        if (e_r == '0) begin
          rmag_nxt  = upsh[adn_pkg::VAL_W-1:0];
          state_nxt = adn_pkg::ST_EMIT;
        end else if (work_r > LIM_10) begin
          rsat_nxt  = 1'b1;
          rmag_nxt  = adn_pkg::MAX_Q;
          state_nxt = adn_pkg::ST_EMIT;
        end else begin
          work_nxt = (work_r << 3) + (work_r << 1);
          e_nxt    = e_r - 10'sd1;
        end
      end
      adn_pkg::ST_DIV: begin
        if (sc_r == '0) begin
          if (e_r == '0 || work_r == '0) begin
            if (work_r > MAXQ_W) begin
              rsat_nxt = 1'b1;
              rmag_nxt = adn_pkg::MAX_Q;
            end else begin
              rmag_nxt = work_r[adn_pkg::VAL_W-1:0];
            end
            state_nxt = adn_pkg::ST_EMIT;
          end else begin
            sc_nxt  = SC_W'(STEPS);
            rem_nxt = '0;
          end
        end else begin
          work_nxt = {work_r[WORK_W-5:0], dq};
          rem_nxt  = dr;
          sc_nxt   = sc_r - SC_W'(1);
          if (sc_r == SC_W'(1)) e_nxt = e_r + 10'sd1;
        end
      end
      adn_pkg::ST_EMIT: begin
        if (load) state_nxt = adn_pkg::ST_IDLE;
      end
      default: state_nxt = adn_pkg::ST_IDLE;
    endcase
  end

  // Output side
  always_comb begin
    in_ch.ready = (state_r == adn_pkg::ST_IDLE);
    ovld_nxt = (ovld_r && !out_ch.ready) || load;
    oval_nxt = oval_r;
    osat_nxt = osat_r;
    if (load) begin
      oval_nxt = rneg_r ? -$signed(rmag_r) : $signed(rmag_r);
      osat_nxt = rsat_r;
    end
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.value     = oval_r;
  assign out_ch.saturated = osat_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= adn_pkg::ST_IDLE;
      phase_r  <= adn_pkg::PH_SKIP;
      prefix_r <= '0;
      skip_r   <= '0;
      neg_r    <= 1'b0;
      mant_r   <= '0;
      dcnt_r   <= '0;
      dsh_r    <= '0;
      eneg_r   <= 1'b0;
      expv_r   <= '0;
      sc_r     <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      if (cfg_wr_en) prefix_r <= cfg_wr_data;
      skip_r   <= skip_nxt;
      neg_r    <= neg_nxt;
      mant_r   <= mant_nxt;
      dcnt_r   <= dcnt_nxt;
      dsh_r    <= dsh_nxt;
      eneg_r   <= eneg_nxt;
      expv_r   <= expv_nxt;
      sc_r     <= sc_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    e_r    <= e_nxt;
    rem_r  <= rem_nxt;
    rneg_r <= rneg_nxt;
    rmag_r <= rmag_nxt;
    rsat_r <= rsat_nxt;
    oval_r <= oval_nxt;
    osat_r <= osat_nxt;
  end

  // Checks
  `CHK_NEXT(a_div_runs, clk, rst_n, state_r == adn_pkg::ST_DIV && sc_r != '0, state_r == adn_pkg::ST_DIV, "divide pass left early")
  `CHK_IMPLY(a_sat_clamp, clk, rst_n, ovld_r && osat_r, oval_r == $signed(adn_pkg::MAX_Q) || oval_r == -$signed(adn_pkg::MAX_Q), "saturated value not clamped")
  `CHK_IMPLY(a_zero_nosat, clk, rst_n, ovld_r && oval_r == '0, !osat_r, "zero flagged saturated")
  `CHK_NEXT(a_last_starts, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.last_char, state_r == adn_pkg::ST_PREP, "last char did not start scaling")

endmodule
